// ===== rtl/circular_queue_with_overwrite_macros.svh =====
// Assertion macros shared by the queue modules.
`ifndef CIRCULAR_QUEUE_WITH_OVERWRITE_MACROS_SVH
`define CIRCULAR_QUEUE_WITH_OVERWRITE_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while arst_n is low.
`define CQO_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, disabled while arst_n is low.
`define CQO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cqo_pkg.sv =====
// Shared types and codes of the circular queue with overwrite.
package cqo_pkg;

	localparam int ACT_W = 2;
	localparam int ST_W  = 2;
	localparam int CAP_W = 5;
	localparam int OCC_W = 5;
	localparam int CFG_IDX_W = 1;

	typedef logic [ACT_W-1:0] action_t;
	typedef logic [ST_W-1:0]  status_t;

	localparam action_t ACT_ENQ  = 2'd0;
	localparam action_t ACT_DEQ  = 2'd1;
	localparam action_t ACT_PEEK = 2'd2;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_FULL      = 2'd1;
	localparam status_t ST_EMPTY     = 2'd2;
	localparam status_t ST_OVERWROTE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE = 1'd1;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Result of one item as decided in the accept cycle.
	typedef struct packed {
		logic              use_ram;
		status_t           status;
		logic [OCC_W-1:0]  occupancy;
	} cqo_result_t;

endpackage

// ===== rtl/cqo_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module cqo_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/cqo_ctrl.sv =====
// Configuration registers, head and tail pointers, entry count and item decode.
`include "circular_queue_with_overwrite_macros.svh"

module cqo_ctrl
	import cqo_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CAP_W-1:0]         cfg_data,
	input  logic                     accept,
	input  action_t                  action,
	output logic                     ram_we,
	output logic [$clog2(DEPTH)-1:0] ram_waddr,
	output logic                     ram_re,
	output logic [$clog2(DEPTH)-1:0] ram_raddr,
	output cqo_result_t              result
);

	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
	localparam int CMP_W   = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;
	localparam logic [CAP_W-1:0] CAP_MAX_V = CAP_W'(CAP_MAX);

	logic [CAP_W-1:0] cap_q;
	logic             ow_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [OCC_W-1:0] cnt_q;

	logic [CAP_W-1:0] cap_eff;
	logic [IDX_W-1:0] head_step;
	logic [IDX_W-1:0] tail_step;
	logic [IDX_W-1:0] head_d;
	logic [IDX_W-1:0] tail_d;
	logic [OCC_W-1:0] cnt_d;
	logic             is_full;
	logic             is_empty;
	logic             wr_en;
	logic             rd_en;
	logic             use_ram;
	status_t          st;

	// Steps an index, wrapping to zero when the next value reaches the capacity.
	function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] idx,
		input logic [CAP_W-1:0] cap);
		logic [CMP_W-1:0] nxt;
		nxt = CMP_W'(idx) + CMP_W'(1);
		return (nxt >= CMP_W'(cap)) ? '0 : nxt[IDX_W-1:0];
	endfunction

	always_comb begin
		cap_eff = cap_q;
		if (cap_q == '0) begin
			cap_eff = CAP_W'(1);
		end else if (cap_q > CAP_MAX_V) begin
			cap_eff = CAP_MAX_V;
		end
	end

	assign head_step = step_idx(head_q, cap_eff);
	assign tail_step = step_idx(tail_q, cap_eff);
	assign is_full   = (cnt_q >= cap_eff);
	assign is_empty  = (cnt_q == '0);

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		cnt_d   = cnt_q;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		use_ram = 1'b0;
		st      = ST_OK;
		unique case (action)
			ACT_ENQ: begin
				if (is_full) begin
					if (ow_q) begin
						wr_en  = 1'b1;
						tail_d = tail_step;
						head_d = head_step;
						st     = ST_OVERWROTE;
					end else begin
						st = ST_FULL;
					end
				end else begin
					wr_en  = 1'b1;
					tail_d = tail_step;
					cnt_d  = cnt_q + OCC_W'(1);
				end
			end
			ACT_DEQ: begin
				if (is_empty) begin
					st = ST_EMPTY;
				end else begin
					rd_en   = 1'b1;
					use_ram = 1'b1;
					head_d  = head_step;
					cnt_d   = cnt_q - OCC_W'(1);
				end
			end
			ACT_PEEK: begin
				if (is_empty) begin
					st = ST_EMPTY;
				end else begin
					rd_en   = 1'b1;
					use_ram = 1'b1;
				end
			end
			default: begin
				// Unused code: no effect, ok status.
				st = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			ow_q   <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CAPACITY:  cap_q <= cfg_data;
					CFG_OVERWRITE: ow_q  <= cfg_data[0];
					default: begin
						cap_q <= cap_q;
					end
				endcase
			end
			if (accept) begin
				head_q <= head_d;
				tail_q <= tail_d;
				cnt_q  <= cnt_d;
			end
		end
	end

	assign ram_we    = accept && wr_en;
	assign ram_waddr = tail_q;
	assign ram_re    = accept && rd_en;
	assign ram_raddr = head_q;

	assign result.use_ram   = use_ram;
	assign result.status    = st;
	assign result.occupancy = cnt_d;

	`CQO_ASSERT_NOW(a_cnt_bounded, 1'b1, cnt_q <= CAP_MAX_V, "entry count above largest capacity")
	`CQO_ASSERT_NEXT(a_reject_holds, accept && (action == ACT_ENQ) && is_full && !ow_q, $stable(cnt_q) && $stable(head_q) && $stable(tail_q), "rejected enqueue changed the queue state")

endmodule

// ===== rtl/circular_queue_with_overwrite.sv =====
// Top level of the circular queue with overwrite: pipeline and output register.
//
//  channel   direction  handshake                    payload
//  in        input      in_valid / in_ready          action, push_data
//  out       output     out_valid / out_ready        pop_data, status, occupancy
//  cfg       input      cfg_we (no wait)             cfg_index, cfg_data
//
// The block takes one item per cycle while the output is not stalled; each result passes
// through stage one and then the output register. Pointers and the count update in the
// accept cycle, when the entry RAM is read or written; the RAM's registered read data sets the stage between.
// A stalled output holds its result while one more item waits in stage one.
// Reset empties the queue at once, sets the capacity to 16 and overwrite off.
`include "circular_queue_with_overwrite_macros.svh"

module circular_queue_with_overwrite
	import cqo_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  action_t               action,
	input  logic [DATA_WIDTH-1:0] push_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] pop_data,
	output status_t               status,
	output logic [OCC_W-1:0]      occupancy,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CAP_W-1:0]      cfg_data
);

	localparam int IDX_W = $clog2(DEPTH);

	logic                  accept;
	logic                  s1_go;
	logic                  ram_we;
	logic                  ram_re;
	logic [IDX_W-1:0]      ram_waddr;
	logic [IDX_W-1:0]      ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;
	cqo_result_t           result;

	// Stage one waits for the RAM read data.
	logic                  valid_s1;
	cqo_result_t           result_s1;

	// Output register.
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] pop_data_q;
	status_t               status_q;
	logic [OCC_W-1:0]      occupancy_q;

	// Stage one moves whenever the output register is empty or being emptied.
	assign s1_go    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_go;
	assign accept   = in_valid && in_ready;

	cqo_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.action   (action),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.result   (result)
	);

	// A write at one edge is visible to a read issued at the next, so a dequeue
	// right after an enqueue to the same slot needs no forwarding.
	cqo_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(push_data),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_s1 <= result;
		end
		if (s1_go) begin
			pop_data_q  <= result_s1.use_ram ? ram_rdata : '0;
			status_q    <= result_s1.status;
			occupancy_q <= result_s1.occupancy;
		end
	end

	assign out_valid = out_valid_q;
	assign pop_data  = pop_data_q;
	assign status    = status_q;
	assign occupancy = occupancy_q;

	`CQO_ASSERT_NOW(a_no_accept_when_blocked, valid_s1 && out_valid_q && !out_ready, !in_ready, "item accepted while both stages were blocked")
	`CQO_ASSERT_NEXT(a_ram_data_loaded, s1_go && result_s1.use_ram, out_valid_q && (pop_data_q == $past(ram_rdata)), "head word not loaded into the output register")

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the circular queue with overwrite.
module testbench
	import cqo_pkg::*;
();

	localparam int DEPTH = 16;
	localparam int DATA_WIDTH = 64;
	localparam int SLOT_W = $clog2(DEPTH);

	// Action code 3 has no meaning; the block must answer it with an ok and no change.
	localparam action_t ACT_UNUSED = 2'd3;

	// The random part runs in phases, each opening with a fresh register setting.
	localparam int RANDOM_PHASES = 22;
	localparam int ITEMS_PER_PHASE = 90;
	localparam int QUIET_PHASES = 3;

	// Idle cycles waited after the last owed result comes out, to cover any stragglers.
	localparam int SETTLE_CYCLES = 6;

	localparam int DIRECTED_ROWS = 27;

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [SLOT_W-1:0] slot_t;

	typedef struct packed {
		word_t            pop_data;
		status_t          status;
		logic [OCC_W-1:0] occupancy;
	} queue_result_t;

	// A row of the directed table either writes a register or sends one item. An item row
	// either carries its result typed in, or leaves the result to the queue mirror.
	typedef enum logic [1:0] {ROW_CFG, ROW_PREDICTED, ROW_TYPED} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CAP_W-1:0]      reg_value;
		action_t               act;
		word_t                 data;
		queue_result_t         want;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	action_t               action;
	word_t                 push_data;
	logic                  out_valid;
	logic                  out_ready;
	word_t                 pop_data;
	status_t               status;
	logic [OCC_W-1:0]      occupancy;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CAP_W-1:0]      cfg_data;

	// Mirror of the queue: the entry store, which slots have ever been written, the two
	// indices, the count and both registers. It is advanced once per accepted item.
	word_t             mirror_store [DEPTH];
	bit                mirror_written [DEPTH];
	slot_t             mirror_head = '0;
	slot_t             mirror_tail = '0;
	logic [OCC_W-1:0]  mirror_count = '0;
	logic [CAP_W-1:0]  mirror_capacity = CAP_RESET;
	logic              mirror_overwrite = 1'b0;

	// Results owed by the block, oldest first.
	queue_result_t awaited_results [$];
	int mismatches = 0;

	// While set, neither side of the block idles.
	bit quiet = 1'b0;

	plan_row_t directed_plan [DIRECTED_ROWS];

	circular_queue_with_overwrite #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.push_data (push_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pop_data  (pop_data),
		.status    (status),
		.occupancy (occupancy),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// A zero capacity behaves as one entry, and anything above the store size as the
	// whole store.
	function automatic int usable_slots();
		int cap;
		cap = int'(mirror_capacity);
		if (cap < 1) cap = 1;
		if (cap > DEPTH) cap = DEPTH;
		return cap;
	endfunction

	// Indices wrap to zero as soon as the next value would reach the usable capacity,
	// which also holds for an index left above a capacity that was lowered.
	function automatic slot_t next_slot(slot_t idx, int cap);
		return (int'(idx) + 1 >= cap) ? slot_t'(0) : slot_t'(idx + 1'b1);
	endfunction

	// Works out the result of one item and moves the mirror on by it.
	task automatic ring_step(input action_t act, input word_t data, output queue_result_t res);
		int cap;
		cap = usable_slots();
		res = '0;
		res.status = ST_OK;
		case (act)
			ACT_ENQ: begin
				if (int'(mirror_count) >= cap) begin
					// A full queue either drops its oldest entry or turns the word away.
					if (mirror_overwrite) begin
						mirror_store[mirror_tail] = data;
						mirror_written[mirror_tail] = 1'b1;
						mirror_tail = next_slot(mirror_tail, cap);
						mirror_head = next_slot(mirror_head, cap);
						res.status = ST_OVERWROTE;
					end else begin
						res.status = ST_FULL;
					end
				end else begin
					mirror_store[mirror_tail] = data;
					mirror_written[mirror_tail] = 1'b1;
					mirror_tail = next_slot(mirror_tail, cap);
					mirror_count = mirror_count + 1'b1;
				end
			end
			ACT_DEQ, ACT_PEEK: begin
				if (mirror_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.pop_data = mirror_store[mirror_head];
					if (act == ACT_DEQ) begin
						mirror_head = next_slot(mirror_head, cap);
						mirror_count = mirror_count - 1'b1;
					end
				end
			end
			default: begin
				// The unused code leaves everything as it is.
			end
		endcase
		res.occupancy = mirror_count;
	endtask

	function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] val);
		plan_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.reg_index = idx;
		r.reg_value = val;
		return r;
	endfunction

	function automatic plan_row_t item_row(action_t act, word_t data);
		plan_row_t r;
		r = '0;
		r.kind = ROW_PREDICTED;
		r.act = act;
		r.data = data;
		return r;
	endfunction

	function automatic plan_row_t typed_row(action_t act, word_t data, word_t pop, status_t st,
			logic [OCC_W-1:0] occ);
		plan_row_t r;
		r = item_row(act, data);
		r.kind = ROW_TYPED;
		r.want.pop_data = pop;
		r.want.status = st;
		r.want.occupancy = occ;
		return r;
	endfunction

	// Sends one item, starting and ending on a falling edge. The mirror is advanced at the
	// rising edge that accepts the item, so the next item is always chosen from the queue
	// state that the block will see.
	task automatic drive_item(input action_t act, input word_t data, input bit use_typed,
			input queue_result_t typed_result);
		queue_result_t predicted;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		push_data <= data;
		do @(posedge clk); while (!in_ready);
		ring_step(act, data, predicted);
		awaited_results.push_back(use_typed ? typed_result : predicted);
		@(negedge clk);
	endtask

	// Registers change only once every owed result has come out, so no item in flight
	// sees a setting that the mirror did not use for it.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CAP_W-1:0] val);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CAPACITY:  mirror_capacity = val;
			CFG_OVERWRITE: mirror_overwrite = val[0];
			default: ;
		endcase
	endtask

	// Random items lean toward enqueue or dequeue by phase so that the queue sweeps from
	// empty to full and back. Peeks and the unused code are mixed in as noise.
	task automatic pick_random_item(input int enq_pct, output action_t act, output word_t data);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			act = ACT_UNUSED;
		end else if (roll < 11) begin
			act = ACT_PEEK;
		end else begin
			act = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
		end
		// After the capacity drops with entries held, the head can land on a slot that was
		// never written; its contents are undefined, so such a read is never sent.
		if ((act == ACT_DEQ || act == ACT_PEEK) && mirror_count != 0
				&& !mirror_written[mirror_head]) begin
			act = ACT_ENQ;
		end
		case ($urandom_range(0, 15))
			0: data = '0;
			1: data = '1;
			default: data = {$urandom, $urandom};
		endcase
	endtask

	// Result side: out_ready is dropped at random, in bursts.
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Every result is held against the oldest one owed, field by field.
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$error("result with no item outstanding: pop_data %h status %0d occupancy %0d",
					pop_data, status, occupancy);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				if (pop_data !== want.pop_data) begin
					$error("pop_data: expected %h, got %h", want.pop_data, pop_data);
					mismatches++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int phase;
		int enq_pct;
		action_t act;
		word_t data;
		logic [CAP_W-1:0] cap_pick;

		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_ENQ;
		push_data = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_CAPACITY;
		cfg_data = '0;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. After reset the queue is empty with sixteen entries and overwrite
		// off. The rows walk the empty answers, the unused code, the all-ones and all-zeros
		// words, a rejected and an overwriting enqueue at capacity two, a zero capacity
		// that acts as one entry, and a capacity above the store that acts as sixteen.
		directed_plan = '{
			typed_row(ACT_PEEK, '0, '0, ST_EMPTY, 5'd0),
			typed_row(ACT_DEQ, '1, '0, ST_EMPTY, 5'd0),
			typed_row(ACT_UNUSED, '1, '0, ST_OK, 5'd0),
			typed_row(ACT_ENQ, '1, '0, ST_OK, 5'd1),
			typed_row(ACT_PEEK, '0, '1, ST_OK, 5'd1),
			typed_row(ACT_ENQ, '0, '0, ST_OK, 5'd2),
			typed_row(ACT_DEQ, '0, '1, ST_OK, 5'd1),
			typed_row(ACT_DEQ, '1, '0, ST_OK, 5'd0),
			cfg_row(CFG_CAPACITY, 5'd2),
			item_row(ACT_ENQ, 64'hA5A5_A5A5_A5A5_A5A5),
			item_row(ACT_ENQ, 64'h5A5A_5A5A_5A5A_5A5A),
			typed_row(ACT_ENQ, 64'h0000_0000_0000_1234, '0, ST_FULL, 5'd2),
			cfg_row(CFG_OVERWRITE, 5'd1),
			typed_row(ACT_ENQ, 64'h0123_4567_89AB_CDEF, '0, ST_OVERWROTE, 5'd2),
			item_row(ACT_PEEK, '0),
			item_row(ACT_DEQ, '0),
			item_row(ACT_DEQ, '0),
			typed_row(ACT_DEQ, '0, '0, ST_EMPTY, 5'd0),
			cfg_row(CFG_CAPACITY, 5'd0),
			item_row(ACT_ENQ, 64'd1),
			typed_row(ACT_ENQ, 64'd2, '0, ST_OVERWROTE, 5'd1),
			typed_row(ACT_DEQ, '0, 64'd2, ST_OK, 5'd0),
			cfg_row(CFG_CAPACITY, 5'd31),
			cfg_row(CFG_OVERWRITE, 5'd0),
			item_row(ACT_ENQ, 64'h8000_0000_0000_0000),
			item_row(ACT_UNUSED, 64'h8000_0000_0000_0001),
			item_row(ACT_DEQ, '0)
		};

		foreach (directed_plan[i]) begin
			case (directed_plan[i].kind)
				ROW_CFG: write_register(directed_plan[i].reg_index, directed_plan[i].reg_value);
				ROW_TYPED: drive_item(directed_plan[i].act, directed_plan[i].data, 1'b1,
					directed_plan[i].want);
				default: drive_item(directed_plan[i].act, directed_plan[i].data, 1'b0, '0);
			endcase
		end

		// Random part. The first phases sweep the capacity through its extremes, out-of-range
		// values among them; later ones draw it at random. The queue is not drained between
		// phases, so capacity often changes with entries held.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: cap_pick = 5'd16;
				1: cap_pick = 5'd1;
				2: cap_pick = 5'd0;
				3: cap_pick = 5'd31;
				4: cap_pick = 5'd17;
				5: cap_pick = 5'd2;
				6: cap_pick = 5'd3;
				7: cap_pick = 5'd16;
				8: cap_pick = 5'd5;
				9: cap_pick = 5'd15;
				default: cap_pick = CAP_W'($urandom_range(0, 31));
			endcase
			write_register(CFG_CAPACITY, cap_pick);
			write_register(CFG_OVERWRITE, CAP_W'((phase % 3) != 0));

			// The closing phases run without idling; a few others do too, at random.
			quiet = (phase >= RANDOM_PHASES - QUIET_PHASES) || ($urandom_range(0, 4) == 0);

			case (phase % 3)
				0: enq_pct = 75;
				1: enq_pct = 50;
				default: enq_pct = 25;
			endcase

			repeat (ITEMS_PER_PHASE) begin
				pick_random_item(enq_pct, act, data);
				drive_item(act, data, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// A correct run takes well under a tenth of this.
	initial begin
		#8000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cqo_pkg.sv
rtl/cqo_ram.sv
rtl/cqo_ctrl.sv
rtl/circular_queue_with_overwrite.sv
dv/testbench.sv
